// File: rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants for modular exponentiation
// Prime modulus, Barrett reciprocal, operand widths and sequencer states.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int unsigned EXP_BITS_DEF = 31;

  localparam int unsigned VAL_W  = 30;            // residue / base / power width
  localparam int unsigned OPND_W = 31;            // shared multiplier operand width
  localparam int unsigned PROD_W = 2 * OPND_W;    // shared multiplier product width
  localparam int unsigned RED_W  = 32;            // partial remainder width (< 3P)

  localparam logic [VAL_W-1:0]  PRIME_MOD  = 30'd1000000007;
  localparam logic [RED_W-1:0]  PRIME_X1   = 32'd1000000007;
  localparam logic [RED_W-1:0]  PRIME_X2   = 32'd2000000014;
  localparam logic [OPND_W-1:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

  localparam logic [VAL_W-1:0]  VAL_ONE    = 30'd1;

  // modmul unit sequencer
  typedef enum logic [2:0] {
    MM_IDLE,
    MM_QEST,
    MM_QP,
    MM_SUB,
    MM_FIX
  } mm_state_t;

  // exponent sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SQR,
    ST_SQR_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_DONE
  } exp_state_t;

endpackage

// File: rtl/mep_mulmod.sv
// ----------------------------------------------------------------------------
// mep_mulmod: multi-cycle modular multiplier
// a*b mod P with one shared 31x31 multiplier: product, Barrett quotient
// estimate, quotient times P, subtract, final correction.
// ----------------------------------------------------------------------------
module mep_mulmod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mep_pkg::VAL_W-1:0] a,
  input  logic [mep_pkg::VAL_W-1:0] b,
  output logic                      done,
  output logic [mep_pkg::VAL_W-1:0] result
);
  import mep_pkg::*;

  mm_state_t           state, state_next;
  logic [PROD_W-1:0]   prod, prod_next;
  logic [RED_W-1:0]    xlow, xlow_next;
  logic [RED_W-1:0]    r, r_next;
  logic [VAL_W-1:0]    result_next;
  logic                done_next;
  logic [OPND_W-1:0]   op_x, op_y;
  logic [PROD_W-1:0]   mult;

  assign mult = op_x * op_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= prod_next;
    xlow   <= xlow_next;
    r      <= r_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    prod_next   = prod;
    xlow_next   = xlow;
    r_next      = r;
    result_next = result;
    done_next   = 1'b0;
    op_x        = {1'b0, a};
    op_y        = {1'b0, b};
    case (state)
      MM_IDLE: begin
        if (start) begin
          prod_next  = mult;
          state_next = MM_QEST;
        end
      end
      MM_QEST: begin
        // q = ((x >> 29) * mu) >> 31, off by at most two
        op_x       = prod[59:29];
        op_y       = BARRETT_MU;
        xlow_next  = prod[RED_W-1:0];
        prod_next  = mult;
        state_next = MM_QP;
      end
      MM_QP: begin
        op_x       = prod[PROD_W-1:OPND_W];
        op_y       = {1'b0, PRIME_MOD};
        prod_next  = mult;
        state_next = MM_SUB;
      end
      MM_SUB: begin
        // remainder is below 3P, so 32 low bits are exact
        r_next     = xlow - prod[RED_W-1:0];
        state_next = MM_FIX;
      end
      MM_FIX: begin
        if (r >= PRIME_X2) begin
          result_next = VAL_W'(r - PRIME_X2);
        end else if (r >= PRIME_X1) begin
          result_next = VAL_W'(r - PRIME_X1);
        end else begin
          result_next = r[VAL_W-1:0];
        end
        done_next  = 1'b1;
        state_next = MM_IDLE;
      end
      default: begin
        state_next = MM_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/modular_exponentiation_prime.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_prime: base^exponent mod 1000000007
// Left-to-right square-and-multiply on one shared modular multiplier.
// ----------------------------------------------------------------------------
// One beat in gives one beat out: power = base^exponent mod 1000000007.
// Exponent 0 returns 1 and exponent 1 returns base untouched (not reduced);
// anything larger returns a fully reduced residue. For a modular inverse
// send exponent 1000000005. The block works on one item at a time and
// holds in_stall high until the result is in the output register, which
// can sit waiting on out_stall while the next beat is taken. Run time is
// set by the shared mep_mulmod unit: an item with exponent 0 or 1 does
// not use it; otherwise leading zero bits are skipped one per cycle,
// then each significant exponent bit costs one modular square and each
// one among them an extra modular multiply.
// ----------------------------------------------------------------------------
module modular_exponentiation_prime #(
  parameter int unsigned EXP_BITS = mep_pkg::EXP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mep_pkg::VAL_W-1:0] base,
  input  logic [EXP_BITS-1:0]       exponent,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mep_pkg::VAL_W-1:0] power
);
  import mep_pkg::*;

  localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

  exp_state_t          state, state_next;
  logic                out_valid_next;
  logic [VAL_W-1:0]    breg, breg_next;     // base held for the multiply step
  logic [EXP_BITS-1:0] ereg, ereg_next;     // exponent, MSB is the current bit
  logic [CNT_W-1:0]    cnt, cnt_next;       // exponent bits still to process
  logic [VAL_W-1:0]    acc, acc_next;       // running power
  logic [VAL_W-1:0]    power_next;

  logic                mm_start;
  logic [VAL_W-1:0]    mm_a, mm_b;
  logic                mm_done;
  logic [VAL_W-1:0]    mm_result;

  // square uses acc twice, multiply step pairs acc with the base
  assign mm_a = acc;
  assign mm_b = (state == ST_MUL) ? breg : acc;

  mep_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .done   (mm_done),
    .result (mm_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    breg  <= breg_next;
    ereg  <= ereg_next;
    cnt   <= cnt_next;
    acc   <= acc_next;
    power <= power_next;
  end

  always_comb begin
    state_next     = state;
    breg_next      = breg;
    ereg_next      = ereg;
    cnt_next       = cnt;
    acc_next       = acc;
    power_next     = power;
    mm_start       = 1'b0;
    in_stall       = (state != ST_IDLE);
    out_valid_next = out_valid;

    // output beat taken
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          breg_next = base;
          if (exponent == '0) begin
            acc_next   = VAL_ONE;
            state_next = ST_DONE;
          end else if (exponent == EXP_BITS'(1)) begin
            // passed through as given, no reduction
            acc_next   = base;
            state_next = ST_DONE;
          end else begin
            ereg_next  = exponent;
            cnt_next   = CNT_W'(EXP_BITS);
            acc_next   = VAL_ONE;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // drop leading zeros: squaring 1 leaves 1
        if (ereg[EXP_BITS-1]) begin
          state_next = ST_SQR;
        end else begin
          ereg_next = ereg << 1;
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      ST_SQR: begin
        if (cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          mm_start   = 1'b1;
          state_next = ST_SQR_WAIT;
        end
      end
      ST_SQR_WAIT: begin
        if (mm_done) begin
          acc_next = mm_result;
          if (ereg[EXP_BITS-1]) begin
            state_next = ST_MUL;
          end else begin
            ereg_next  = ereg << 1;
            cnt_next   = cnt - CNT_W'(1);
            state_next = ST_SQR;
          end
        end
      end
      ST_MUL: begin
        mm_start   = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mm_done) begin
          acc_next   = mm_result;
          ereg_next  = ereg << 1;
          cnt_next   = cnt - CNT_W'(1);
          state_next = ST_SQR;
        end
      end
      ST_DONE: begin
        // output register free or emptying this cycle
        if (!out_valid || !out_stall) begin
          power_next     = acc;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
